// ----- rtl/core/lkpq_pkg.sv -----
// Shared constants for the last-k product query block.
`default_nettype none

package lkpq_pkg;

   // ring of stored prefix products
   localparam int RING_DEPTH = 1024;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);

   // field widths
   localparam int VALUE_W = 16;
   localparam int K_W     = 10;
   localparam int PROD_W  = 32;
   localparam int ACC_W   = PROD_W + VALUE_W;

   // serial unit step counts
   localparam int MUL_STEPS = VALUE_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // function codes
   localparam logic FUNC_APPEND = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/last_k_product_query.sv -----
// Last-k product query: prefix-product ring with bit-serial multiply and divide.
// Append of a nonzero value: accept, 16 bit-serial multiply steps and one write.
// Append of zero: accept only. Query: accept and result state when answered directly (k of
// zero, k past the run or ring, k equal to the run), else accept with ring read, load state,
// 32 restoring-divide steps and result state (zero base: no divide); one request at a time.
// Reset (synchronous, active high) clears run count, head slot, overflow flag and the
// result valid flag; the prefix ring is not cleared, only entries of the current run are read.
`default_nettype none

module last_k_product_query (
   input  wire logic        clock,
   input  wire logic        reset,
   // request words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // [15:0] value, [25:16] window_length, [31:26] zero
   input  wire logic [0:0]  req_tuser,  // [0] func
   // result words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,  // [31:0] product
   output logic      [0:0]  rsp_tuser   // [0] overflow
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_WRITE,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam int IDX_W  = lkpq_pkg::IDX_W;
   localparam int CNT_W  = lkpq_pkg::CNT_W;
   localparam int PROD_W = lkpq_pkg::PROD_W;
   localparam int ACC_W  = lkpq_pkg::ACC_W;
   localparam int VAL_W  = lkpq_pkg::VALUE_W;
   localparam int STEP_W = lkpq_pkg::STEP_W;

   // control state
   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [CNT_W-1:0]    run_count_ff, run_count_in;
   logic                overflow_seen_ff, overflow_seen_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload
   logic [PROD_W-1:0]   newest_ff, newest_in;     // newest prefix of the run
   logic [PROD_W-1:0]   mcand_ff, mcand_in;
   logic [VAL_W-1:0]    mplier_ff, mplier_in;     // shifted out MSB first
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [PROD_W-1:0]   divisor_ff, divisor_in;
   logic [PROD_W-1:0]   rem_ff, rem_in;
   logic [PROD_W-1:0]   quo_ff, quo_in;           // dividend in, quotient out; holds result
   logic                res_ovf_ff, res_ovf_in;
   logic [PROD_W-1:0]   rsp_product_ff, rsp_product_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   // request fields
   logic                req_func;
   logic [VAL_W-1:0]    req_value;
   logic [lkpq_pkg::K_W-1:0] req_k;
   logic                req_accept;
   logic [31:0]         k32;
   logic [31:0]         rc32;
   logic [IDX_W-1:0]    back;
   logic [IDX_W:0]      slot_sum;
   logic [IDX_W-1:0]    base_slot;

   // datapath helpers
   logic [PROD_W:0]     trial;
   logic [PROD_W:0]     trial_diff;
   logic                sat;
   logic [PROD_W-1:0]   prefix_w;

   // ring port
   logic                ram_we;
   logic                ram_re;
   logic [PROD_W-1:0]   ram_rdata;

   assign req_func   = req_tuser[0];
   assign req_value  = req_tdata[VAL_W-1:0];
   assign req_k      = req_tdata[VAL_W +: lkpq_pkg::K_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // base prefix slot: head - 1 - k, modulo ring depth (k below depth here)
   assign k32       = 32'(req_k);
   assign rc32      = 32'(run_count_ff);
   assign back      = IDX_W'(k32);
   assign slot_sum  = (IDX_W + 1)'(head_ff) + (IDX_W + 1)'(lkpq_pkg::RING_DEPTH)
                      - (IDX_W + 1)'(1) - (IDX_W + 1)'(back);
   assign base_slot = (slot_sum >= (IDX_W + 1)'(lkpq_pkg::RING_DEPTH))
                      ? IDX_W'(slot_sum - (IDX_W + 1)'(lkpq_pkg::RING_DEPTH))
                      : IDX_W'(slot_sum);

   // restoring divide step
   assign trial      = {rem_ff, quo_ff[PROD_W-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};

   // prefix saturates at the 32-bit ceiling
   assign sat      = |acc_ff[ACC_W-1:PROD_W];
   assign prefix_w = sat ? {PROD_W{1'b1}} : acc_ff[PROD_W-1:0];

   assign ram_we = (state_ff == ST_WRITE);
   assign ram_re = req_accept && (req_func == lkpq_pkg::FUNC_QUERY) && (k32 != 32'd0)
                   && (k32 <= rc32) && (k32 < 32'(lkpq_pkg::RING_DEPTH)) && (k32 != rc32);

   lkpq_ram #(
      .WIDTH (PROD_W),
      .DEPTH (lkpq_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (head_ff),
      .wr_data (prefix_w),
      .rd_en   (ram_re),
      .rd_addr (base_slot),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in         = state_ff;
      head_in          = head_ff;
      run_count_in     = run_count_ff;
      overflow_seen_in = overflow_seen_ff;
      step_in          = step_ff;
      newest_in        = newest_ff;
      mcand_in         = mcand_ff;
      mplier_in        = mplier_ff;
      acc_in           = acc_ff;
      divisor_in       = divisor_ff;
      rem_in           = rem_ff;
      quo_in           = quo_ff;
      res_ovf_in       = res_ovf_ff;
      rsp_product_in   = rsp_product_ff;
      rsp_ovf_in       = rsp_ovf_ff;
      rsp_valid_in     = rsp_valid_ff;

      // result word taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_func == lkpq_pkg::FUNC_APPEND) begin
                  if (req_value == '0) begin
                     // zero ends the run
                     run_count_in     = '0;
                     overflow_seen_in = 1'b0;
                  end else begin
                     mcand_in  = (run_count_ff != '0) ? newest_ff : PROD_W'(1);
                     mplier_in = req_value;
                     acc_in    = '0;
                     step_in   = '0;
                     state_in  = ST_MUL;
                  end
               end else begin
                  res_ovf_in = overflow_seen_ff;
                  if (k32 == 32'd0) begin
                     quo_in   = PROD_W'(1);   // empty product
                     state_in = ST_DONE;
                  end else if ((k32 > rc32) || (k32 >= 32'(lkpq_pkg::RING_DEPTH))) begin
                     quo_in   = '0;           // window reaches a zero or left the ring
                     state_in = ST_DONE;
                  end else if (k32 == rc32) begin
                     quo_in   = newest_ff;    // base is the implicit one
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_LOAD;      // ring read in flight
                  end
               end
            end
         end

         ST_MUL: begin
            acc_in    = {acc_ff[ACC_W-2:0], 1'b0}
                        + (mplier_ff[VAL_W-1] ? ACC_W'(mcand_ff) : ACC_W'(0));
            mplier_in = {mplier_ff[VAL_W-2:0], 1'b0};
            step_in   = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(lkpq_pkg::MUL_STEPS - 1)) begin
               state_in = ST_WRITE;
            end
         end

         ST_WRITE: begin
            newest_in        = prefix_w;
            head_in          = (head_ff == IDX_W'(lkpq_pkg::RING_DEPTH - 1))
                               ? '0 : head_ff + IDX_W'(1);
            if (run_count_ff != CNT_W'(lkpq_pkg::RING_DEPTH)) begin
               run_count_in = run_count_ff + CNT_W'(1);
            end
            overflow_seen_in = overflow_seen_ff | sat;
            state_in         = ST_IDLE;
         end

         ST_LOAD: begin
            divisor_in = ram_rdata;
            if (ram_rdata == '0) begin
               quo_in   = {PROD_W{1'b1}};     // zero base
               state_in = ST_DONE;
            end else begin
               quo_in   = newest_ff;
               rem_in   = '0;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            if (trial >= {1'b0, divisor_ff}) begin
               rem_in = trial_diff[PROD_W-1:0];
               quo_in = {quo_ff[PROD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[PROD_W-1:0];
               quo_in = {quo_ff[PROD_W-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(lkpq_pkg::DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in   = 1'b1;
               rsp_product_in = quo_ff;
               rsp_ovf_in     = res_ovf_ff;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         head_ff          <= '0;
         run_count_ff     <= '0;
         overflow_seen_ff <= 1'b0;
         step_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         head_ff          <= head_in;
         run_count_ff     <= run_count_in;
         overflow_seen_ff <= overflow_seen_in;
         step_ff          <= step_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      newest_ff      <= newest_in;
      mcand_ff       <= mcand_in;
      mplier_ff      <= mplier_in;
      acc_ff         <= acc_in;
      divisor_ff     <= divisor_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      res_ovf_ff     <= res_ovf_in;
      rsp_product_ff <= rsp_product_in;
      rsp_ovf_ff     <= rsp_ovf_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_product_ff;
   assign rsp_tuser[0] = rsp_ovf_ff;

   // run count never passes the ring depth
   assert property (@(posedge clock) disable iff (reset)
      run_count_ff <= CNT_W'(lkpq_pkg::RING_DEPTH))
      else $error("run count above ring depth");

   // an appended zero clears the run and the overflow flag
   assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_func == lkpq_pkg::FUNC_APPEND) && (req_value == '0)
      |=> (run_count_ff == '0) && !overflow_seen_ff)
      else $error("zero append did not clear the run");

   // the divider never runs on a zero base
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (divisor_ff != '0))
      else $error("divide by zero base");

   // a new result word only comes out of the result state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result word without a finished query");

endmodule

`default_nettype wire

// ----- rtl/core/lkpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lkpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- tb/sv/last_k_product_query_tb.sv -----
// Self-checking stream testbench for the last-k product query block.
`timescale 1ns / 1ps

module last_k_product_query_tb;

   localparam int CYCLE_LIMIT = 600_000;   // many times the slowest clean run
   localparam int DRAIN_CYCLES = 40;       // a bit past one full divide

   // one expected result word
   typedef struct packed {
      logic [lkpq_pkg::PROD_W-1:0] product;
      logic                        overflow;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [15:0] value, [25:16] window_length, [31:26] zero
   logic [0:0]  req_tuser = '0;   // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] product
   logic [0:0]  rsp_tuser;        // [0] overflow

   // predictor state: own copy of the prefix ring and run bookkeeping
   logic [lkpq_pkg::PROD_W-1:0] prefix_copy [0:lkpq_pkg::RING_DEPTH-1];
   int                head_idx = 0;
   int                run_len = 0;
   logic              ovf_flag = 1'b0;

   answer_type expected_products[$];   // answers owed by the block, oldest first
   int      mismatch_count = 0;
   int      words_sent = 0;
   int      cycle_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;

   last_k_product_query DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("last_k_product_query verification failed");
         $finish;
      end
   end

   // ring slot holding the prefix 'back' steps behind the newest
   function automatic int slot_behind(input int back);
      return (head_idx + lkpq_pkg::RING_DEPTH - 1 - back) % lkpq_pkg::RING_DEPTH;
   endfunction

   // advance the prefix products for one accepted word; queries owe an answer
   task automatic advance_prefix_products(input logic fn,
                                          input logic [lkpq_pkg::VALUE_W-1:0] v,
                                          input logic [lkpq_pkg::K_W-1:0] k);
      logic [63:0]                 wide;
      logic [lkpq_pkg::PROD_W-1:0] newest;
      logic [lkpq_pkg::PROD_W-1:0] base;
      answer_type                  ans;
      if (fn == lkpq_pkg::FUNC_APPEND) begin
         if (v == '0) begin
            // zero ends the run and clears the sticky flag
            run_len = 0;
            ovf_flag = 1'b0;
         end else begin
            wide = (run_len != 0) ? 64'(prefix_copy[slot_behind(0)]) : 64'd1;
            wide = wide * 64'(v);
            if (wide > 64'hFFFF_FFFF) begin
               // saturate and mark the run unreliable
               wide = 64'hFFFF_FFFF;
               ovf_flag = 1'b1;
            end
            prefix_copy[head_idx] = wide[lkpq_pkg::PROD_W-1:0];
            head_idx = (head_idx + 1) % lkpq_pkg::RING_DEPTH;
            if (run_len < lkpq_pkg::RING_DEPTH) run_len++;
         end
      end else begin
         if (k == '0) begin
            ans.product = 32'd1;                 // empty product
         end else if (int'(k) > run_len || int'(k) >= lkpq_pkg::RING_DEPTH) begin
            ans.product = '0;                    // window hits a zero or stream start
         end else begin
            newest = prefix_copy[slot_behind(0)];
            base = (int'(k) == run_len) ? 32'd1 : prefix_copy[slot_behind(int'(k))];
            ans.product = (base != '0) ? newest / base : 32'hFFFF_FFFF;
         end
         ans.overflow = ovf_flag;
         expected_products.insert(expected_products.size(), ans);
      end
   endtask

   // drive one request word at the falling edge, hold until taken
   task automatic send_word(input logic fn, input logic [lkpq_pkg::VALUE_W-1:0] v,
                            input logic [lkpq_pkg::K_W-1:0] k);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {6'b0, k, v};
      do @(posedge clock); while (!req_tready);
      words_sent++;
      advance_prefix_products(fn, v, k);
   endtask

   task automatic flag_bad_answer(input string what, input answer_type want,
                                  input logic [lkpq_pkg::PROD_W-1:0] got_product,
                                  input logic got_ovf);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s: expected product %h overflow %b, got product %h overflow %b",
                  what, want.product, want.overflow, got_product, got_ovf);
   endtask

   // result side: random back-pressure, changed at the falling edge
   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

   // score each result word against the oldest owed answer
   always @(posedge clock) begin : check_results
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_products.size() == 0) begin
            want = '0;
            flag_bad_answer("result with nothing pending", want, rsp_tdata, rsp_tuser[0]);
         end else begin
            want = expected_products.pop_front();
            if (rsp_tdata !== want.product || rsp_tuser[0] !== want.overflow)
               flag_bad_answer("result mismatch", want, rsp_tdata, rsp_tuser[0]);
         end
      end
   end

   // window edges: k of zero, k equal to the run, k past the run, clears
   task automatic test_window_edges();
      send_word(lkpq_pkg::FUNC_QUERY, 16'hFFFF, 10'd0);      // empty run, empty window
      send_word(lkpq_pkg::FUNC_QUERY, 16'h0000, 10'd1);      // past an empty run
      send_word(lkpq_pkg::FUNC_APPEND, 16'hFFFF, 10'h3FF);   // largest value
      send_word(lkpq_pkg::FUNC_QUERY, 16'h0000, 10'd1);      // k equals the run
      send_word(lkpq_pkg::FUNC_APPEND, 16'd1, 10'd0);
      send_word(lkpq_pkg::FUNC_APPEND, 16'd2, 10'd0);
      send_word(lkpq_pkg::FUNC_APPEND, 16'd3, 10'd0);
      send_word(lkpq_pkg::FUNC_QUERY, 16'd0, 10'd2);         // divide by stored base
      send_word(lkpq_pkg::FUNC_QUERY, 16'd0, 10'd4);         // whole run, base of one
      send_word(lkpq_pkg::FUNC_QUERY, 16'd0, 10'd5);         // one past the run
      send_word(lkpq_pkg::FUNC_QUERY, 16'hFFFF, 10'h3FF);    // largest k
      send_word(lkpq_pkg::FUNC_QUERY, 16'd0, 10'd0);
      send_word(lkpq_pkg::FUNC_APPEND, 16'd0, 10'h3FF);      // zero clears the run
      send_word(lkpq_pkg::FUNC_QUERY, 16'd0, 10'd1);
      send_word(lkpq_pkg::FUNC_QUERY, 16'd0, 10'd0);
   endtask

   // sticky overflow: set by a saturated prefix, cleared only by a zero
   task automatic test_overflow_sticky();
      send_word(lkpq_pkg::FUNC_APPEND, 16'hFFFF, 10'd0);
      send_word(lkpq_pkg::FUNC_APPEND, 16'hFFFF, 10'd0);     // still fits in 32 bits
      send_word(lkpq_pkg::FUNC_APPEND, 16'hFFFF, 10'd0);     // saturates
      send_word(lkpq_pkg::FUNC_QUERY, 16'd0, 10'd1);
      send_word(lkpq_pkg::FUNC_QUERY, 16'd0, 10'd3);
      send_word(lkpq_pkg::FUNC_APPEND, 16'd7, 10'd0);        // flag stays set
      send_word(lkpq_pkg::FUNC_QUERY, 16'd0, 10'd1);
      send_word(lkpq_pkg::FUNC_APPEND, 16'd0, 10'd0);
      send_word(lkpq_pkg::FUNC_APPEND, 16'd5, 10'd0);
      send_word(lkpq_pkg::FUNC_QUERY, 16'd0, 10'd1);         // flag clear again
   endtask

   // one long run: wide windows reach far back into the ring
   task automatic test_long_run();
      int doublings;
      logic [lkpq_pkg::VALUE_W-1:0] v;
      doublings = 0;
      send_word(lkpq_pkg::FUNC_APPEND, 16'd0, 10'($urandom));
      for (int i = 0; i < 300; i++) begin
         v = 16'd1;
         if (doublings < 20 && $urandom_range(0, 49) == 0) begin
            v = 16'd2;
            doublings++;
         end
         send_word(lkpq_pkg::FUNC_APPEND, v, 10'($urandom));
         if (i % 50 == 49)
            send_word(lkpq_pkg::FUNC_QUERY, 16'($urandom),
                      10'($urandom_range(1, (run_len < 1023) ? run_len : 1023)));
      end
      send_word(lkpq_pkg::FUNC_QUERY, 16'($urandom), 10'd300);   // k equals the run
      send_word(lkpq_pkg::FUNC_QUERY, 16'($urandom), 10'd299);   // oldest stored base
      send_word(lkpq_pkg::FUNC_QUERY, 16'($urandom), 10'd150);
      send_word(lkpq_pkg::FUNC_QUERY, 16'($urandom), 10'd1);
      send_word(lkpq_pkg::FUNC_QUERY, 16'($urandom), 10'd0);
   endtask

   // mostly short runs with queries inside them, some raw noise
   task automatic test_random_mix(input int word_goal);
      int stop_at;
      int steps;
      logic [lkpq_pkg::VALUE_W-1:0] v;
      stop_at = words_sent + word_goal;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 1))
               send_word(lkpq_pkg::FUNC_APPEND, 16'd0, 10'($urandom));
            steps = $urandom_range(1, 12);
            for (int i = 0; i < steps; i++) begin
               if ($urandom_range(0, 2) != 0) begin
                  case ($urandom_range(0, 9))
                     0:       v = 16'($urandom_range(1, 65535));  // pushes toward overflow
                     1, 2:    v = 16'($urandom_range(16, 255));
                     default: v = 16'($urandom_range(1, 15));
                  endcase
                  send_word(lkpq_pkg::FUNC_APPEND, v, 10'($urandom));
               end else begin
                  send_word(lkpq_pkg::FUNC_QUERY, 16'($urandom),
                            10'($urandom_range(0, run_len + 2)));
               end
            end
         end else begin
            send_word(1'($urandom), 16'($urandom), 10'($urandom));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // sender idles 29%, receiver 49%
      send_idle_pct = 29;
      recv_idle_pct = 49;
      test_window_edges();
      test_overflow_sticky();
      test_random_mix(170);

      // roles swapped
      send_idle_pct = 49;
      recv_idle_pct = 29;
      test_random_mix(170);

      // full rate both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_long_run();
      test_random_mix(170);

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_products.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("last_k_product_query verification clean");
      else
         $display("last_k_product_query verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/lkpq_pkg.sv
rtl/core/lkpq_ram.sv
rtl/core/last_k_product_query.sv
tb/sv/last_k_product_query_tb.sv
